// ----- design/audio_wave_segmenter_top_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef AUDIO_WAVE_SEGMENTER_TOP_MACROS_SVH
`define AUDIO_WAVE_SEGMENTER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is held
`define AWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held
`define AWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/aws_pkg.sv -----
`timescale 1ns / 1ps

package aws_pkg;

  // Widths
  localparam int POS_BITS   = 24;
  localparam int START_W    = 24;
  localparam int LEN_W      = 25;
  localparam int SAMPLE_W   = 8;
  localparam int PEAK_W     = 8;
  localparam int GAIN_W     = 14;
  localparam int GAP_W      = 16;
  localparam int RATIO_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int DROP_W     = POS_BITS + RATIO_W;
  localparam int DIV_CNT_W  = 4;

  // Gain numerator and register reset values
  localparam logic [GAIN_W-1:0]    GAIN_NUM      = GAIN_W'(12700);
  localparam logic [GAP_W-1:0]     MIN_GAP_RST   = GAP_W'(2000);
  localparam logic [RATIO_W-1:0]   DROP_RATIO_RST = RATIO_W'(5);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST      = DIV_CNT_W'(GAIN_W - 1);

  // Class thresholds on s*gain: the scaled value s*gain/100 >> 2 is above 8
  // exactly when s*gain >= 3600, and equal to 8 when 3200 <= s*gain < 3600.
  // Saturation never moves a value across these points.
  localparam logic signed [PROD_W-1:0] PROD_HI  = PROD_W'(3600);
  localparam logic signed [PROD_W-1:0] PROD_MID = PROD_W'(3200);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_RATIO = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } wave_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CLS,
    ST_EW1,
    ST_LMUL,
    ST_EW2,
    ST_FIN
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic peak_upd;
    logic div_start;
    logic div_step;
    logic mul;
    logic classify;
    logic end_wave;
    logic new_wave;
    logic emit_final;
    logic clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gain_ready;
    logic div_last;
    logic wave_ends;
    logic seg_cut;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ----- design/audio_wave_segmenter_top.sv -----
`timescale 1ns / 1ps
// Audio wave segmenter.
// Input channel (in_valid_i / in_stall_o) carries req_type, sample and last.
// A recording is sent twice: first as req_type 0 items (peak pass), then as
// req_type 1 items (segmenting pass) with last on the final one.
// Output channel (out_valid_o / out_stall_i) carries one item per segment:
// start position, length and a final flag on the closing segment.
// A peak-pass item only updates the peak magnitude. A segmenting item is
// captured, multiplied and classified, with one more step when it closes a
// wave. The first segmenting item of a pass first runs the bit-serial gain
// divider. The final item ends by returning the block to its reset state, configuration apart.
// A segment item appears in the output register in the cycle after the wave
// that closes it is tested. A new input item is taken while a result waits
// in the output register; if the receiver stalls, an item that closes a
// wave, and the final item, wait until the register frees, holding off the
// input meanwhile.
// Reset clears the control, tracking and result state and loads min_gap = 2000, drop_ratio = 5.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken.

module audio_wave_segmenter_top import aws_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [START_W-1:0]         seg_start_o,
  output logic [LEN_W-1:0]           seg_length_o,
  output logic                       seg_final_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  aws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aws_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .seg_start_o  (seg_start_o),
    .seg_length_o (seg_length_o),
    .seg_final_o  (seg_final_o)
  );

endmodule

// ----- design/aws_ctrl.sv -----
`timescale 1ns / 1ps

module aws_ctrl import aws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    req_type_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i) begin
            cmd_o.load_item = 1'b1;
            if (status_i.gain_ready) begin
              state_d = ST_MUL;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end
          end else begin
            cmd_o.peak_upd = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CLS;
      end
      ST_CLS: begin
        cmd_o.classify = 1'b1;
        if (status_i.wave_ends) begin
          state_d = ST_EW1;
        end else if (status_i.last) begin
          state_d = ST_LMUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EW1: begin
        // wave closed by a change of class; the item opens the next one
        if (status_i.out_free) begin
          cmd_o.end_wave = 1'b1;
          cmd_o.new_wave = 1'b1;
          if (!status_i.last) begin
            state_d = ST_IDLE;
          end else if (status_i.seg_cut) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_LMUL;
          end
        end
      end
      ST_LMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EW2;
      end
      ST_EW2: begin
        // open wave tested at end of input
        if (status_i.out_free) begin
          cmd_o.end_wave = 1'b1;
          state_d        = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          cmd_o.clear      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/aws_dpath.sv -----
`timescale 1ns / 1ps

module aws_dpath import aws_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [START_W-1:0]         seg_start_o,
  output logic [LEN_W-1:0]           seg_length_o,
  output logic                       seg_final_o
);

  // Configuration
  logic [GAP_W-1:0]   min_gap_q;
  logic [RATIO_W-1:0] drop_ratio_q;

  // Item and arithmetic
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic [PEAK_W-1:0]          peak_q;
  logic [PEAK_W-1:0]          mag;
  logic [PEAK_W-1:0]          divisor;
  logic [GAIN_W-1:0]          gain_q;
  logic                       gain_ready_q;
  logic [GAIN_W-1:0]          num_q;
  logic [PEAK_W:0]            rem_q;
  logic [PEAK_W:0]            rem_trial;
  logic                       rem_ge;
  logic [DIV_CNT_W-1:0]       div_cnt_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [DROP_W-1:0]          drop_prod_q;
  wave_class_e                class_now;
  wave_class_e                class_q;

  // Wave and segment tracking
  wave_class_e         wave_class_q;
  logic [POS_BITS-1:0] wave_len_q;
  logic [POS_BITS-1:0] prev_wave_len_q;
  logic [POS_BITS-1:0] wave_begin_q;
  logic [POS_BITS-1:0] sample_pos_q;
  logic [POS_BITS-1:0] item_pos_q;
  logic [POS_BITS-1:0] segment_begin_q;
  logic [POS_BITS-1:0] last_drop_pos_q;
  logic [POS_BITS:0]   gap_limit;
  logic                is_drop;
  logic                seg_cut;
  logic                wave_ends;

  // Result register
  logic                out_valid_q;
  logic [START_W-1:0]  seg_start_q;
  logic [LEN_W-1:0]    seg_length_q;
  logic                seg_final_q;
  logic                out_free;
  logic [POS_BITS-1:0] cut_len;
  logic [POS_BITS:0]   final_len;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q    <= MIN_GAP_RST;
      drop_ratio_q <= DROP_RATIO_RST;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        CFG_MIN_GAP:    min_gap_q    <= cfg_data_i[GAP_W-1:0];
        CFG_DROP_RATIO: drop_ratio_q <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sample_q <= sample_i;
      last_q   <= last_i;
    end
  end

  // Peak magnitude: two's complement negation of -128 reads as 128 unsigned
  assign mag = sample_i[SAMPLE_W-1] ? PEAK_W'(-sample_i) : PEAK_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (cmd_i.clear) begin
      peak_q <= '0;
    end else if (cmd_i.peak_upd && (mag > peak_q)) begin
      peak_q <= mag;
    end
  end

  // Gain divider, one quotient bit per cycle, restoring
  assign divisor   = (peak_q == '0) ? PEAK_W'(1) : peak_q;
  assign rem_trial = {rem_q[PEAK_W-1:0], num_q[GAIN_W-1]};
  assign rem_ge    = (rem_trial >= {1'b0, divisor});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q     <= '0;
      num_q     <= GAIN_NUM;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? (rem_trial - {1'b0, divisor}) : rem_trial;
      num_q     <= {num_q[GAIN_W-2:0], 1'b0};
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= '0;
      gain_ready_q <= 1'b0;
    end else if (cmd_i.clear) begin
      gain_q       <= '0;
      gain_ready_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      gain_q <= '0;
    end else if (cmd_i.div_step) begin
      gain_q <= {gain_q[GAIN_W-2:0], rem_ge};
      if (div_cnt_q == DIV_LAST) begin
        gain_ready_q <= 1'b1;
      end
    end
  end

  // Products: scaled sample and drop test
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q      <= sample_q * $signed({1'b0, gain_q});
      drop_prod_q <= DROP_W'(wave_len_q) * DROP_W'(drop_ratio_q);
    end
  end

  // Class of the scaled sample
  always_comb begin
    if (prod_q >= PROD_HI) begin
      class_now = CLS_POS;
    end else if (prod_q >= PROD_MID) begin
      class_now = CLS_ZERO;
    end else begin
      class_now = CLS_NEG;
    end
  end

  assign wave_ends = (wave_len_q != '0) && (class_now != wave_class_q) &&
                     (class_now != CLS_ZERO);

  // Drop and segment-cut decision for the wave being closed
  assign is_drop   = (drop_prod_q < DROP_W'(prev_wave_len_q));
  assign gap_limit = (POS_BITS+1)'(last_drop_pos_q) + (POS_BITS+1)'(min_gap_q);
  assign seg_cut   = is_drop && ((POS_BITS+1)'(wave_begin_q) > gap_limit);

  // Wave state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_class_q <= CLS_ZERO;
      wave_len_q   <= '0;
      wave_begin_q <= '0;
      sample_pos_q <= '0;
    end else if (cmd_i.clear) begin
      wave_class_q <= CLS_ZERO;
      wave_len_q   <= '0;
      wave_begin_q <= '0;
      sample_pos_q <= '0;
    end else if (cmd_i.classify) begin
      sample_pos_q <= sample_pos_q + POS_BITS'(1);
      if (wave_len_q == '0) begin
        wave_class_q <= class_now;
        wave_begin_q <= sample_pos_q;
        wave_len_q   <= POS_BITS'(1);
      end else if (!wave_ends) begin
        wave_len_q <= wave_len_q + POS_BITS'(1);
      end
    end else if (cmd_i.new_wave) begin
      wave_class_q <= class_q;
      wave_begin_q <= item_pos_q;
      wave_len_q   <= POS_BITS'(1);
    end
  end

  // Class and position of the item in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      class_q    <= class_now;
      item_pos_q <= sample_pos_q;
    end
  end

  // Segment and drop history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_wave_len_q <= '0;
      segment_begin_q <= '0;
      last_drop_pos_q <= '0;
    end else if (cmd_i.clear) begin
      prev_wave_len_q <= '0;
      segment_begin_q <= '0;
      last_drop_pos_q <= '0;
    end else if (cmd_i.end_wave) begin
      prev_wave_len_q <= wave_len_q;
      if (is_drop) begin
        last_drop_pos_q <= wave_begin_q;
      end
      if (seg_cut) begin
        segment_begin_q <= wave_begin_q;
      end
    end
  end

  // Result register; the position difference wraps at POS_BITS
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cut_len   = wave_begin_q - segment_begin_q;
  assign final_len = {1'b0, item_pos_q - segment_begin_q} + (POS_BITS+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.end_wave && seg_cut) || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.end_wave && seg_cut) begin
      seg_start_q  <= START_W'(segment_begin_q);
      seg_length_q <= LEN_W'(cut_len);
      seg_final_q  <= 1'b0;
    end else if (cmd_i.emit_final) begin
      seg_start_q  <= START_W'(segment_begin_q);
      seg_length_q <= LEN_W'(final_len);
      seg_final_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign seg_start_o  = seg_start_q;
  assign seg_length_o = seg_length_q;
  assign seg_final_o  = seg_final_q;

  // Status
  assign status_o.gain_ready = gain_ready_q;
  assign status_o.div_last   = (div_cnt_q == DIV_LAST);
  assign status_o.wave_ends  = wave_ends;
  assign status_o.seg_cut    = seg_cut;
  assign status_o.last       = last_q;
  assign status_o.out_free   = out_free;

endmodule

// ----- design/aws_checker.sv -----
`timescale 1ns / 1ps
`include "audio_wave_segmenter_top_macros.svh"

module aws_checker import aws_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       req_type_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [START_W-1:0]         seg_start_o,
  input logic [LEN_W-1:0]           seg_length_o,
  input logic                       seg_final_o
);

  // a stalled result item stays put
  `AWS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(seg_start_o) && $stable(seg_length_o) && $stable(seg_final_o), "stalled result item changed")

  // a segmenting item always keeps the block busy for the next cycle
  `AWS_ASSERT_NEXT(a_seg_busy, in_valid_i && !in_stall_o && req_type_i, in_stall_o, "segmenting item did not occupy the block")

  // a peak-pass item leaves the input free in the next cycle
  `AWS_ASSERT_NEXT(a_peak_fast, in_valid_i && !in_stall_o && !req_type_i, !in_stall_o, "peak item stalled the input")

endmodule

bind audio_wave_segmenter_top aws_checker u_aws_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import aws_pkg::*;

  localparam int GAIN_DIVIDEND = 12700;
  localparam int SCALE_DIV     = 100;
  localparam int SAT_HI        = 127;
  localparam int SAT_LO        = -128;
  localparam int CLASS_LEVEL   = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_GAP       = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [START_W-1:0] begin_pos;
    logic [LEN_W-1:0]   len;
    logic               closing;
  } segment_t;

  // Block ports
  logic                       clk_i;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic                       req_type_i   = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_i     = '0;
  logic                       last_i       = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [START_W-1:0]         seg_start_o;
  logic [LEN_W-1:0]           seg_length_o;
  logic                       seg_final_o;
  logic                       cfg_valid_i  = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i  = CFG_MIN_GAP;
  logic [CFG_DATA_W-1:0]      cfg_data_i   = '0;

  // Run control
  int cycle_count   = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;

  // Segmenter state as the testbench sees it
  logic [GAP_W-1:0]    gap_cfg;
  logic [RATIO_W-1:0]  ratio_cfg;
  logic [PEAK_W-1:0]   peak_q;
  logic [GAIN_W-1:0]   gain_q;
  logic                gain_ok;
  wave_class_e         run_class;
  logic [POS_BITS-1:0] run_len;
  logic [POS_BITS-1:0] prev_run_len;
  logic [POS_BITS-1:0] run_begin;
  logic [POS_BITS-1:0] next_pos;
  logic [POS_BITS-1:0] seg_begin;
  logic [POS_BITS-1:0] drop_pos;

  segment_t segments_due[$];

  audio_wave_segmenter_top i_dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("audio_wave_segmenter_top verification failed");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[cycle %0d] %s: expected %0d, got %0d", cycle_count, what, want, got);
  endtask

  // Compare every accepted segment with the oldest one predicted
  always @(posedge clk_i) begin
    segment_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (segments_due.size() == 0) begin
        report_mismatch("segment with none pending, start", -1, seg_start_o);
      end else begin
        due = segments_due.pop_front();
        if (seg_start_o !== due.begin_pos)
          report_mismatch("seg_start", due.begin_pos, seg_start_o);
        if (seg_length_o !== due.len)
          report_mismatch("seg_length", due.len, seg_length_o);
        if (seg_final_o !== due.closing)
          report_mismatch("seg_final", due.closing, seg_final_o);
      end
    end
  end

  function automatic void clear_prediction();
    peak_q       = '0;
    gain_q       = '0;
    gain_ok      = 1'b0;
    run_class    = CLS_ZERO;
    run_len      = '0;
    prev_run_len = '0;
    run_begin    = '0;
    next_pos     = '0;
    seg_begin    = '0;
    drop_pos     = '0;
  endfunction

  // Scale by gain/100, saturate, shift right by two, compare with the level
  function automatic wave_class_e class_of(input int s);
    int prod;
    int scaled;
    int level;
    prod   = s * int'(gain_q);
    scaled = prod / SCALE_DIV;
    if (scaled > SAT_HI) scaled = SAT_HI;
    if (scaled < SAT_LO) scaled = SAT_LO;
    level = scaled >>> 2;
    if (level > CLASS_LEVEL) return CLS_POS;
    if (level < CLASS_LEVEL) return CLS_NEG;
    return CLS_ZERO;
  endfunction

  // Drop test on the wave just ended; may cut the current segment
  function automatic int close_wave();
    segment_t seg;
    int emitted;
    emitted = 0;
    if (longint'(run_len) * longint'(ratio_cfg) < longint'(prev_run_len)) begin
      if (longint'(run_begin) > longint'(drop_pos) + longint'(gap_cfg)) begin
        seg.begin_pos = START_W'(seg_begin);
        seg.len       = LEN_W'(POS_BITS'(run_begin - seg_begin));
        seg.closing   = 1'b0;
        segments_due.push_back(seg);
        emitted   = 1;
        seg_begin = run_begin;
      end
      drop_pos = run_begin;
    end
    prev_run_len = run_len;
    return emitted;
  endfunction

  function automatic void predict_segments(input logic req, input int s, input logic fin);
    int                  mag;
    int                  emitted;
    logic                ended;
    wave_class_e         q;
    logic [POS_BITS-1:0] pos;
    segment_t            seg;
    // Peak pass: track magnitude only, last has no effect
    if (!req) begin
      mag = (s < 0) ? -s : s;
      if (mag > int'(peak_q)) peak_q = PEAK_W'(mag);
      return;
    end
    if (!gain_ok) begin
      gain_q  = GAIN_W'(GAIN_DIVIDEND / ((peak_q == 0) ? 1 : int'(peak_q)));
      gain_ok = 1'b1;
    end
    q       = class_of(s);
    pos     = next_pos;
    emitted = 0;
    ended   = 1'b0;
    if (run_len == 0) begin
      run_class = q;
      run_begin = pos;
      run_len   = POS_BITS'(1);
    end else if (q == run_class || q == CLS_ZERO) begin
      run_len = run_len + POS_BITS'(1);
    end else begin
      emitted   = close_wave();
      ended     = 1'b1;
      run_class = q;
      run_begin = pos;
      run_len   = POS_BITS'(1);
    end
    next_pos = pos + POS_BITS'(1);
    // Closing sample: test the open wave unless a cut just happened
    if (fin) begin
      if (!(ended && emitted > 0)) emitted += close_wave();
      seg.begin_pos = START_W'(seg_begin);
      seg.len       = LEN_W'(POS_BITS'(pos - seg_begin)) + LEN_W'(1);
      seg.closing   = 1'b1;
      segments_due.push_back(seg);
      clear_prediction();
    end
  endfunction

  task automatic send_sample(input logic req, input int s, input logic fin);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    sample_i   <= SAMPLE_W'(s);
    last_i     <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_segments(req, s, fin);
    items_sent++;
  endtask

  // Block idle: all segments in, then the closing latency
  task automatic wait_settled();
    in_valid_i <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] gap_data,
                           input logic [CFG_DATA_W-1:0] ratio_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MIN_GAP;
    cfg_data_i  <= gap_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gap_cfg = gap_data;
    cfg_index_i <= CFG_DROP_RATIO;
    cfg_data_i  <= ratio_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ratio_cfg = ratio_data[RATIO_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  // A recording of alternating waves, long and short mixed, sent mostly over both passes
  task automatic play_recording(input int n, input int amp);
    int  rec[$];
    int  run;
    int  pick;
    int  s;
    int  hi;
    bit  up;
    hi = (amp > SAT_HI) ? SAT_HI : amp;
    up = ($urandom_range(1) != 0);
    while (rec.size() < n) begin
      run = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 25);
      repeat (run) begin
        pick = $urandom_range(99);
        if (pick < 8)       s = (3400 * amp + GAIN_DIVIDEND / 2) / GAIN_DIVIDEND;
        else if (pick < 12) s = int'($urandom_range(255)) - 128;
        else if (up)        s = $urandom_range(hi / 2, hi);
        else                s = -int'($urandom_range(0, amp));
        rec.push_back(s);
      end
      up = !up;
    end
    // now and then no peak pass at all, so the peak stays zero
    if ($urandom_range(9) != 0)
      foreach (rec[k]) send_sample(1'b0, rec[k], 1'($urandom_range(1)));
    foreach (rec[k]) send_sample(1'b1, rec[k], k == rec.size() - 1);
  endtask

  // Reset settings; first wave never a drop; a drop too near the start makes no cut
  task automatic test_reset_defaults();
    int wave[8] = '{127, 1, 64, 3, 90, 5, -128, 127};
    foreach (wave[k]) send_sample(1'b1, wave[k], k == 7);
  endtask

  // Final sample ends a short wave: a cut and the closing segment together
  task automatic test_closing_pair();
    int wave[8] = '{1, 127, 2, 126, 3, 125, 0, 1};
    wait_settled();
    configure(CFG_DATA_W'(0), CFG_DATA_W'(5));
    foreach (wave[k]) send_sample(1'b1, wave[k], k == 7);
  endtask

  // -128 in the peak pass, last ignored there, class-zero sample, peak item mid-pass
  task automatic test_peak_pass();
    wait_settled();
    configure(16'hFFFF, 16'hFFFF);
    send_sample(1'b0, -128, 1'b0);
    send_sample(1'b0, 127, 1'b1);
    send_sample(1'b1, 34, 1'b0);
    send_sample(1'b1, 40, 1'b0);
    send_sample(1'b1, -5, 1'b0);
    send_sample(1'b0, 100, 1'b0);
    send_sample(1'b1, 127, 1'b1);
  endtask

  // Ratio of zero: every wave after a nonzero one counts as a drop
  task automatic test_zero_ratio();
    int wave[5] = '{1, 1, -1, -1, 2};
    wait_settled();
    configure(CFG_DATA_W'(1), CFG_DATA_W'(0));
    foreach (wave[k]) send_sample(1'b1, wave[k], k == 4);
  endtask

  task automatic run_random_phase(input int send_pct, input int rx_pct, input int quota);
    int target;
    int next_cfg;
    int amp;
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
    target        = items_sent + quota;
    next_cfg      = items_sent;
    while (items_sent < target) begin
      if (items_sent >= next_cfg) begin
        wait_settled();
        configure(($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(25, 65535))
                                           : CFG_DATA_W'($urandom_range(0, 24)),
                  CFG_DATA_W'($urandom_range(1, 15)));
        next_cfg = items_sent + 110;
      end
      if ($urandom_range(7) == 0) begin
        // loose items: any type, any sample, stray last
        repeat ($urandom_range(1, 6))
          send_sample(1'($urandom_range(1)), int'($urandom_range(255)) - 128,
                      $urandom_range(7) == 0);
      end else begin
        amp = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 128);
        play_recording($urandom_range(6, 45), amp);
      end
    end
  endtask

  // Receiver holds off while a cut-heavy recording streams in
  task automatic test_output_backpressure();
    int k;
    wait_settled();
    send_idle_pct = 0;
    stall_pct     = 0;
    configure(CFG_DATA_W'(0), CFG_DATA_W'(1));
    hold_left = HOLD_CYCLES;
    send_sample(1'b0, 100, 1'b0);
    for (k = 0; k < 88; k++)
      send_sample(1'b1, (k % 11 == 10) ? -50 : 50 + (k % 11) * 5, k == 87);
  endtask

  initial begin
    clear_prediction();
    gap_cfg   = MIN_GAP_RST;
    ratio_cfg = DROP_RATIO_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_closing_pair();
    test_peak_pass();
    test_zero_ratio();
    run_random_phase(10, 86, 280);
    run_random_phase(86, 10, 280);
    run_random_phase(0, 0, 280);
    test_output_backpressure();
    wait_settled();

    if (mismatches == 0) begin
      $display("audio_wave_segmenter_top verification clean");
    end else begin
      $display("audio_wave_segmenter_top verification failed");
    end
    $finish;
  end

endmodule
